[rtl/plta_pkg.sv]
// Shared types and constants for the packet-locked three-way arbiter.
`default_nettype none

package plta_pkg;

  localparam int CMD_BITS  = 64;
  localparam int DATA_BITS = 64;
  localparam int QID_BITS  = 12;

  // Depth of the result queue between the front and back parts.
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // Keep masks: clear the qid field and bits above the word width.
  localparam logic [63:0] QID_MASK  = (64'd1 << QID_BITS) - 64'd1;
  localparam logic [63:0] CMD_KEEP  = ((64'd1 << CMD_BITS) - 64'd1) & ~QID_MASK;
  localparam logic [63:0] DATA_KEEP = ((64'd1 << DATA_BITS) - 64'd1) & ~QID_MASK;

  // Grant codes.
  localparam logic [1:0] GRANT_SRC0 = 2'd0;
  localparam logic [1:0] GRANT_SRC1 = 2'd1;
  localparam logic [1:0] GRANT_SRC2 = 2'd2;
  localparam logic [1:0] GRANT_NONE = 2'd3;

  typedef struct packed {
    logic [2:0]  pair_ready_mask;
    logic [2:0]  data_ready_mask;
    logic [2:0]  last_mask;
    logic [63:0] src0_cmd;
    logic [63:0] src1_cmd;
    logic [63:0] src2_cmd;
    logic [63:0] src0_data;
    logic [63:0] src1_data;
    logic [63:0] src2_data;
  } item_t;

  typedef struct packed {
    logic [1:0]  grant;
    logic        cmd_valid;
    logic [63:0] cmd_word;
    logic        data_valid;
    logic [63:0] data_word;
    logic        data_last;
    logic        in_packet;
    logic [31:0] start_count;
  } result_t;

  // Queue status seen by the front part.
  typedef struct packed {
    logic full;
  } qstat_t;

endpackage

`default_nettype wire

[rtl/plta_front.sv]
// Front part: arbitration, packet lock and result formation for each item.
`default_nettype none

module plta_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  input  wire plta_pkg::item_t   item,
  input  wire plta_pkg::qstat_t  qstat,
  output logic                   push,
  output plta_pkg::result_t      res
);

  logic        locked, locked_next;
  logic [1:0]  locked_source, locked_source_next;
  logic [1:0]  last_grant, last_grant_next;
  logic [31:0] packet_starts, packet_starts_next;
  logic [1:0]  pick;
  logic [63:0] cmd_sel, data_sel;
  logic [1:0]  src;

  function automatic logic [1:0] pick_source(input logic [2:0] ready, input logic [1:0] prev);
    logic [1:0] s;
    s = plta_pkg::GRANT_NONE;
    case (ready)
      3'b001: s = plta_pkg::GRANT_SRC0;
      3'b010: s = plta_pkg::GRANT_SRC1;
      3'b100: s = plta_pkg::GRANT_SRC2;
      3'b011: s = (prev == plta_pkg::GRANT_SRC0) ? plta_pkg::GRANT_SRC1 : plta_pkg::GRANT_SRC0;
      3'b101: s = (prev == plta_pkg::GRANT_SRC2) ? plta_pkg::GRANT_SRC0 : plta_pkg::GRANT_SRC2;
      3'b110: s = (prev == plta_pkg::GRANT_SRC1) ? plta_pkg::GRANT_SRC2 : plta_pkg::GRANT_SRC1;
      3'b111: s = (prev >= plta_pkg::GRANT_SRC2) ? plta_pkg::GRANT_SRC0 : prev + 2'd1;
      default: s = plta_pkg::GRANT_NONE;
    endcase
    return s;
  endfunction

  assign push = item_valid && !qstat.full;
  assign pick = pick_source(item.pair_ready_mask, last_grant);
  assign src  = locked ? locked_source : pick;

  always_comb begin
    case (src)
      plta_pkg::GRANT_SRC0: begin
        cmd_sel  = item.src0_cmd;
        data_sel = item.src0_data;
      end
      plta_pkg::GRANT_SRC1: begin
        cmd_sel  = item.src1_cmd;
        data_sel = item.src1_data;
      end
      plta_pkg::GRANT_SRC2: begin
        cmd_sel  = item.src2_cmd;
        data_sel = item.src2_data;
      end
      default: begin
        cmd_sel  = '0;
        data_sel = '0;
      end
    endcase
  end

  always_comb begin
    res                = '0;
    res.grant          = plta_pkg::GRANT_NONE;
    res.in_packet      = locked;
    res.start_count    = packet_starts;
    locked_next        = locked;
    locked_source_next = locked_source;
    last_grant_next    = last_grant;
    packet_starts_next = packet_starts;
    if (!locked) begin
      last_grant_next = pick;
      if (pick != plta_pkg::GRANT_NONE) begin
        res.grant      = pick;
        res.cmd_valid  = 1'b1;
        res.cmd_word   = cmd_sel & plta_pkg::CMD_KEEP;
        res.data_valid = 1'b1;
        res.data_word  = data_sel & plta_pkg::DATA_KEEP;
        res.data_last  = item.last_mask[pick];
        if (!item.last_mask[pick]) begin
          locked_next        = 1'b1;
          locked_source_next = pick;
        end
        packet_starts_next = packet_starts + 32'd1;
      end
    end else if (item.data_ready_mask[locked_source]) begin
      res.grant      = locked_source;
      res.data_valid = 1'b1;
      res.data_word  = data_sel & plta_pkg::DATA_KEEP;
      res.data_last  = item.last_mask[locked_source];
      if (item.last_mask[locked_source]) begin
        locked_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      locked        <= 1'b0;
      locked_source <= plta_pkg::GRANT_SRC0;
      last_grant    <= plta_pkg::GRANT_SRC0;
      packet_starts <= '0;
    end else if (push) begin
      locked        <= locked_next;
      locked_source <= locked_source_next;
      last_grant    <= last_grant_next;
      packet_starts <= packet_starts_next;
    end
  end

  // No command word leaves while locked mid-packet.
  a_no_cmd_when_locked: assert property (@(posedge clk) disable iff (rst)
    push && locked |-> !res.cmd_valid)
    else $error("command emitted while locked");

  // Packet starts advance by one exactly on each emitted command.
  a_start_count: assert property (@(posedge clk) disable iff (rst)
    !rst |=> packet_starts == $past(packet_starts) + 32'($past(push && res.cmd_valid)))
    else $error("packet start count out of step");

  // The lock source is always a real source.
  a_lock_source: assert property (@(posedge clk) disable iff (rst)
    locked |-> locked_source != plta_pkg::GRANT_NONE)
    else $error("locked to the none code");

endmodule

`default_nettype wire

[rtl/plta_queue.sv]
// Short result queue between the front and back parts.
`default_nettype none

module plta_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire plta_pkg::result_t  push_data,
  input  wire logic               pop,
  output logic                    q_valid,
  output plta_pkg::result_t       q_data,
  output plta_pkg::qstat_t        qstat
);

  plta_pkg::result_t                 entry [plta_pkg::QDEPTH];
  logic [plta_pkg::QPTR_W-1:0]       wr_ptr, rd_ptr;
  logic [plta_pkg::QCNT_W-1:0]       count;
  logic                              do_pop;

  localparam logic [plta_pkg::QPTR_W-1:0] LAST_PTR = plta_pkg::QPTR_W'(plta_pkg::QDEPTH - 1);

  assign q_valid     = count != '0;
  assign q_data      = entry[rd_ptr];
  assign do_pop      = pop && q_valid;
  assign qstat.full  = count == plta_pkg::QCNT_W'(plta_pkg::QDEPTH);

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    qstat.full |-> !push)
    else $error("push into a full queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= plta_pkg::QCNT_W'(plta_pkg::QDEPTH))
    else $error("queue count beyond depth");

endmodule

`default_nettype wire

[rtl/plta_back.sv]
// Back part: output register that presents results to the receiver.
`default_nettype none

module plta_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               q_valid,
  input  wire plta_pkg::result_t  q_data,
  output logic                    pop,
  output logic                    result_valid,
  input  wire logic               result_stall,
  output plta_pkg::result_t       result
);

  assign pop = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (pop) begin
      result_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && q_valid) begin
      result <= q_data;
    end
  end

  a_drain: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_stall && !q_valid |=> !result_valid)
    else $error("result shown twice");

endmodule

`default_nettype wire

[rtl/packet_locked_three_way_arbiter.sv]
// Top level of the packet-locked three-way arbiter.
// Usage:
//   The item channel (item_valid, item_stall, item) carries one snapshot of
//   the three sources per transfer: ready masks, last flags, command and data
//   heads. The result channel (result_valid, result_stall, result) returns
//   exactly one result per item: the grant (3 for none), the command word and
//   first beat on a packet start, or a lone data beat while locked, with the
//   qid fields cleared, plus the lock flag and packet start count as they
//   stood before the item.
//   Throughput: one item per cycle while item_stall is low; the arbitration
//   and lock update in the front part are combinational, and its state feeds the next item.
//   After the item transfer the result is written into the queue; the back
//   part then loads it from there into the output register.
//   When the receiver stalls, the result register holds and the two-entry
//   queue fills; item_stall rises once the queue is full and falls as soon as
//   an entry drains.
//   Reset (rst, synchronous) clears the lock, the last grant, the start count
//   and the queue; no result is valid after reset.
`default_nettype none

module packet_locked_three_way_arbiter (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               item_valid,
  output logic                    item_stall,
  input  wire plta_pkg::item_t    item,
  output logic                    result_valid,
  input  wire logic               result_stall,
  output plta_pkg::result_t       result
);

  plta_pkg::result_t fr_res;
  plta_pkg::result_t q_data;
  plta_pkg::qstat_t  qstat;
  logic              push;
  logic              pop;
  logic              q_valid;

  // Stall the item side only while the queue has no free entry.
  assign item_stall = qstat.full;

  // Arbitrate and advance the lock state for every item transfer.
  plta_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .qstat      (qstat),
    .push       (push),
    .res        (fr_res)
  );

  // Hold finished results so the front keeps going under a stall.
  plta_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (fr_res),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .qstat     (qstat)
  );

  // Present results to the receiver from a register.
  plta_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_data       (q_data),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

`default_nettype wire

[verif/plta_checker.sv]
// Channel monitor, arbitration predictor and result comparison for the three-way arbiter.
module plta_checker
  import plta_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  input  logic    item_stall,
  input  item_t   item,
  input  logic    result_valid,
  input  logic    result_stall,
  input  result_t result,
  output int      errors,
  output int      outstanding
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] QID_FIELD = (64'd1 << QID_BITS) - 64'd1;
  localparam logic [63:0] CMD_PASS  =
    ((CMD_BITS >= 64) ? {64{1'b1}} : ((64'd1 << CMD_BITS) - 64'd1)) & ~QID_FIELD;
  localparam logic [63:0] DATA_PASS =
    ((DATA_BITS >= 64) ? {64{1'b1}} : ((64'd1 << DATA_BITS) - 64'd1)) & ~QID_FIELD;

  // Predicted arbiter state.
  logic        locked;
  logic [1:0]  locked_src;
  logic [1:0]  last_grant;
  logic [31:0] starts;

  result_t pending_grants[$];
  result_t want;
  int      mismatches;

  initial begin
    errors      = 0;
    outstanding = 0;
    mismatches  = 0;
    locked      = 1'b0;
    locked_src  = GRANT_SRC0;
    last_grant  = GRANT_SRC0;
    starts      = '0;
  end

  function automatic logic [1:0] choose_source(input logic [2:0] ready, input logic [1:0] prev);
    case (ready)
      3'b001: return GRANT_SRC0;
      3'b010: return GRANT_SRC1;
      3'b100: return GRANT_SRC2;
      3'b011: return (prev == GRANT_SRC0) ? GRANT_SRC1 : GRANT_SRC0;
      3'b101: return (prev == GRANT_SRC2) ? GRANT_SRC0 : GRANT_SRC2;
      3'b110: return (prev == GRANT_SRC1) ? GRANT_SRC2 : GRANT_SRC1;
      3'b111: begin
        if (prev == GRANT_SRC0) return GRANT_SRC1;
        if (prev == GRANT_SRC1) return GRANT_SRC2;
        return GRANT_SRC0;
      end
      default: return GRANT_NONE;
    endcase
  endfunction

  function automatic logic [63:0] cmd_of(input item_t s, input logic [1:0] src);
    case (src)
      GRANT_SRC0: return s.src0_cmd;
      GRANT_SRC1: return s.src1_cmd;
      GRANT_SRC2: return s.src2_cmd;
      default:    return '0;
    endcase
  endfunction

  function automatic logic [63:0] beat_of(input item_t s, input logic [1:0] src);
    case (src)
      GRANT_SRC0: return s.src0_data;
      GRANT_SRC1: return s.src1_data;
      GRANT_SRC2: return s.src2_data;
      default:    return '0;
    endcase
  endfunction

  // Work out the result of one snapshot and advance the predicted state.
  task automatic arbitrate_snapshot(input item_t s, output result_t r);
    logic [1:0] pick;
    r             = '0;
    r.grant       = GRANT_NONE;
    r.in_packet   = locked;
    r.start_count = starts;
    if (!locked) begin
      pick       = choose_source(s.pair_ready_mask, last_grant);
      last_grant = pick;
      if (pick != GRANT_NONE) begin
        r.grant      = pick;
        r.cmd_valid  = 1'b1;
        r.cmd_word   = cmd_of(s, pick) & CMD_PASS;
        r.data_valid = 1'b1;
        r.data_word  = beat_of(s, pick) & DATA_PASS;
        r.data_last  = s.last_mask[pick];
        if (!r.data_last) begin
          locked     = 1'b1;
          locked_src = pick;
        end
        starts = starts + 32'd1;
      end
    end else if (s.data_ready_mask[locked_src]) begin
      r.grant      = locked_src;
      r.data_valid = 1'b1;
      r.data_word  = beat_of(s, locked_src) & DATA_PASS;
      r.data_last  = s.last_mask[locked_src];
      if (r.data_last) locked = 1'b0;
    end
  endtask

  task automatic note_field(input string field, input logic [63:0] got, input logic [63:0] exp_val);
    if (got !== exp_val) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch in %s: expected %h, got %h", field, exp_val, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      locked     = 1'b0;
      locked_src = GRANT_SRC0;
      last_grant = GRANT_SRC0;
      starts     = '0;
      pending_grants.delete();
    end else begin
      if (result_valid && !result_stall) begin
        if (pending_grants.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transfer: %p", result);
        end else begin
          want = pending_grants.pop_front();
          note_field("grant", result.grant, want.grant);
          note_field("cmd_valid", result.cmd_valid, want.cmd_valid);
          note_field("cmd_word", result.cmd_word, want.cmd_word);
          note_field("data_valid", result.data_valid, want.data_valid);
          note_field("data_word", result.data_word, want.data_word);
          note_field("data_last", result.data_last, want.data_last);
          note_field("in_packet", result.in_packet, want.in_packet);
          note_field("start_count", result.start_count, want.start_count);
        end
      end
      if (item_valid && !item_stall) begin
        arbitrate_snapshot(item, want);
        pending_grants.push_back(want);
      end
    end
    outstanding <= pending_grants.size();
    errors      <= mismatches;
  end

endmodule

[verif/tb_top.sv]
// Stimulus and verdict for the packet-locked three-way arbiter.
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  import plta_pkg::*;

  localparam int RANDOM_ITEMS = 1530;
  localparam int QUIET_TAIL   = 150;

  typedef enum int {FILL_ZERO, FILL_ONES, FILL_RANDOM} fill_t;

  logic    clk;
  logic    rst;
  logic    item_valid;
  logic    item_stall;
  item_t   item;
  logic    result_valid;
  logic    result_stall;
  result_t result;
  int      errors;
  int      outstanding;
  bit      idle_on;

  packet_locked_three_way_arbiter uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  // The checker sits beside the block, watching both channels; it owns all prediction.
  plta_checker chk (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .errors       (errors),
    .outstanding  (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop: far beyond the slowest legal run (every transfer waiting out
  // the longest gap and stall on both sides).
  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Receiver side: stall in short random bursts while idling is enabled.
  // Lower the stall in its own step before the next burst can start.
  initial begin
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 4) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  function automatic logic [63:0] fill_word(input fill_t fill);
    case (fill)
      FILL_ZERO: return '0;
      FILL_ONES: return '1;
      default:   return {$urandom, $urandom};
    endcase
  endfunction

  function automatic item_t make_snapshot(input logic [2:0] pm, input logic [2:0] dm,
                                          input logic [2:0] lm, input fill_t fill);
    item_t s;
    s.pair_ready_mask = pm;
    s.data_ready_mask = dm;
    s.last_mask       = lm;
    s.src0_cmd        = fill_word(fill);
    s.src1_cmd        = fill_word(fill);
    s.src2_cmd        = fill_word(fill);
    s.src0_data       = fill_word(fill);
    s.src1_data       = fill_word(fill);
    s.src2_data       = fill_word(fill);
    return s;
  endfunction

  // Offer one snapshot, optionally after a short gap, and hold it until the
  // transfer happens. Valid stays high on return so back-to-back items flow.
  task automatic send_item(input item_t s);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= s;
    @(posedge clk);
    while (item_stall) @(posedge clk);
  endtask

  task automatic send_directed(input logic [2:0] pm, input logic [2:0] dm,
                               input logic [2:0] lm, input fill_t fill);
    send_item(make_snapshot(pm, dm, lm, fill));
  endtask

  initial begin
    logic [2:0] pm;
    logic [2:0] dm;
    logic [2:0] lm;
    int         drain;

    rst        <= 1'b1;
    item_valid <= 1'b0;
    item       <= '0;
    idle_on     = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Nothing ready while idle: no grant, and the rotation restarts from source 0.
    send_directed(3'b000, 3'b000, 3'b000, FILL_ZERO);
    // Full rotation with all three ready, walking through all-ones and all-zero words.
    send_directed(3'b111, 3'b111, 3'b111, FILL_ONES);
    send_directed(3'b111, 3'b111, 3'b111, FILL_ZERO);
    send_directed(3'b111, 3'b111, 3'b111, FILL_RANDOM);
    send_directed(3'b111, 3'b111, 3'b111, FILL_RANDOM);
    // Two-way rules, each from both sides of the previous grant.
    send_directed(3'b011, 3'b011, 3'b011, FILL_RANDOM);
    send_directed(3'b011, 3'b011, 3'b011, FILL_RANDOM);
    send_directed(3'b101, 3'b101, 3'b101, FILL_RANDOM);
    send_directed(3'b101, 3'b101, 3'b101, FILL_RANDOM);
    send_directed(3'b110, 3'b110, 3'b110, FILL_RANDOM);
    send_directed(3'b110, 3'b110, 3'b110, FILL_RANDOM);
    send_directed(3'b110, 3'b110, 3'b110, FILL_RANDOM);
    // Two-way rules straight after an empty cycle.
    send_directed(3'b000, 3'b111, 3'b000, FILL_RANDOM);
    send_directed(3'b011, 3'b011, 3'b111, FILL_RANDOM);
    send_directed(3'b000, 3'b000, 3'b111, FILL_RANDOM);
    send_directed(3'b101, 3'b101, 3'b111, FILL_RANDOM);
    send_directed(3'b000, 3'b000, 3'b000, FILL_RANDOM);
    send_directed(3'b110, 3'b110, 3'b111, FILL_RANDOM);
    // Single sources.
    send_directed(3'b001, 3'b001, 3'b001, FILL_RANDOM);
    send_directed(3'b010, 3'b010, 3'b010, FILL_RANDOM);
    send_directed(3'b100, 3'b100, 3'b100, FILL_RANDOM);
    // Lock onto source 2, stall it for data while the others are ready,
    // then a middle beat and a last beat that release the lock.
    send_directed(3'b100, 3'b111, 3'b000, FILL_ONES);
    send_directed(3'b111, 3'b011, 3'b111, FILL_RANDOM);
    send_directed(3'b000, 3'b100, 3'b000, FILL_ZERO);
    send_directed(3'b111, 3'b111, 3'b100, FILL_ONES);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // Leave quiet windows with no idling, and a fully quiet tail.
      idle_on = !((n >= RANDOM_ITEMS - QUIET_TAIL) || ((n % 300) < 40));

      // Halfway through, drop valid and hold off until every result is back.
      if (n == RANDOM_ITEMS / 2) begin
        item_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
      end

      pm = 3'($urandom_range(0, 7));
      if ($urandom_range(0, 4) == 0) begin
        // Noise: masks with no relation to each other.
        dm = 3'($urandom_range(0, 7));
        lm = 3'($urandom_range(0, 7));
      end else begin
        // Well-formed: sources with a pair also have a data head, data is
        // mostly present, and packets run a few beats before their last flag.
        dm = pm | (($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : 3'b111);
        lm = {($urandom_range(0, 2) == 0), ($urandom_range(0, 2) == 0),
              ($urandom_range(0, 2) == 0)};
      end
      send_item(make_snapshot(pm, dm, lm, FILL_RANDOM));
    end
    item_valid <= 1'b0;

    // Drain: wait for the last results, bounded, then let any stray results show.
    drain = 0;
    do begin
      @(posedge clk);
      drain++;
    end while (outstanding != 0 && drain < 5000);
    repeat (8) @(posedge clk);

    if (errors == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/plta_pkg.sv
rtl/plta_front.sv
rtl/plta_queue.sv
rtl/plta_back.sv
rtl/packet_locked_three_way_arbiter.sv
verif/plta_checker.sv
verif/tb_top.sv
